### rtl/quaternion_alu_top_defines.svh
// Assertion macros shared by the quaternion ALU checker.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef QUATERNION_ALU_TOP_DEFINES_SVH
`define QUATERNION_ALU_TOP_DEFINES_SVH

`define QALU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define QALU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`define QALU_ASSERT_RESET(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/qalu_pkg.sv
`timescale 1ns / 1ps
// Shared widths, types, operation codes and product tables for the quaternion ALU.
// Every RTL module takes its definitions from here by scoped names.
package qalu_pkg;

  localparam int COMP_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int FIELD_W    = 32;
  localparam int NUM_COMP   = 4;
  localparam int IDX_W      = $clog2(NUM_COMP);
  localparam int PROD_W     = 2 * COMP_WIDTH;
  localparam int PAIR_W     = PROD_W + 1;
  localparam int SUM_W      = PROD_W + 2;
  localparam int ADD_W      = COMP_WIDTH + 1;
  localparam int IN_DATA_W  = 2 * NUM_COMP * FIELD_W;
  localparam int OUT_DATA_W = NUM_COMP * FIELD_W;
  localparam int IN_USER_W  = 2;
  localparam int OUT_USER_W = 2;
  localparam int USER_EQUAL = 0;
  localparam int USER_OVF   = 1;

  typedef logic signed [COMP_WIDTH-1:0] comp_t;
  typedef logic signed [ADD_W-1:0]      add_t;
  typedef logic signed [PAIR_W-1:0]     pair_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic signed [FIELD_W-1:0]    field_t;

  localparam comp_t COMP_MAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
  localparam comp_t COMP_MIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};

  typedef enum logic [IN_USER_W-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_CMP = 2'd3
  } op_t;

  // Right-operand component used by each term of each Hamilton product component.
  localparam logic [IDX_W-1:0] RIGHT_IDX [NUM_COMP][NUM_COMP] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd3, 2'd2, 2'd1, 2'd0}
  };

  // A set bit marks a term that is subtracted rather than added.
  localparam logic [NUM_COMP-1:0] TERM_NEG [NUM_COMP] = '{
    4'b1110, 4'b1000, 4'b0010, 4'b0100
  };

  typedef struct packed {
    op_t                                            op;
    logic                                           eq;
    logic [NUM_COMP-1:0][ADD_W-1:0]                 addsub;
    logic [NUM_COMP-1:0][NUM_COMP-1:0][PROD_W-1:0]  prod;
  } s1_t;

  typedef struct packed {
    op_t                                   op;
    logic                                  eq;
    logic [NUM_COMP-1:0][ADD_W-1:0]        addsub;
    logic [NUM_COMP-1:0][1:0][PAIR_W-1:0]  pair;
  } s2_t;

endpackage

### rtl/qalu_mul_stage.sv
`timescale 1ns / 1ps
// First pipeline stage: operand decode, the sixteen partial products, add or subtract
// and the equality test. Depends on qalu_pkg.
module qalu_mul_stage (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  qalu_pkg::op_t                    in_op,
  input  logic [qalu_pkg::IN_DATA_W-1:0]   in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output qalu_pkg::s1_t                    out_data
);

  qalu_pkg::comp_t lhs [qalu_pkg::NUM_COMP];
  qalu_pkg::comp_t rhs [qalu_pkg::NUM_COMP];
  qalu_pkg::s1_t   data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    for (int t = 0; t < qalu_pkg::NUM_COMP; t++) begin
      lhs[t] = in_data[t*qalu_pkg::FIELD_W +: qalu_pkg::COMP_WIDTH];
      rhs[t] = in_data[(qalu_pkg::NUM_COMP+t)*qalu_pkg::FIELD_W +: qalu_pkg::COMP_WIDTH];
    end
  end

  always_comb begin
    data_next.op = in_op;
    data_next.eq = 1'b1;
    for (int t = 0; t < qalu_pkg::NUM_COMP; t++) begin
      if (lhs[t] != rhs[t]) begin
        data_next.eq = 1'b0;
      end
      if (in_op == qalu_pkg::OP_SUB) begin
        data_next.addsub[t] = qalu_pkg::add_t'(lhs[t]) - qalu_pkg::add_t'(rhs[t]);
      end else begin
        data_next.addsub[t] = qalu_pkg::add_t'(lhs[t]) + qalu_pkg::add_t'(rhs[t]);
      end
    end
    for (int c = 0; c < qalu_pkg::NUM_COMP; c++) begin
      for (int t = 0; t < qalu_pkg::NUM_COMP; t++) begin
        data_next.prod[c][t] = qalu_pkg::PROD_W'(lhs[t])
                             * qalu_pkg::PROD_W'(rhs[qalu_pkg::RIGHT_IDX[c][t]]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

### rtl/qalu_sum_stage.sv
`timescale 1ns / 1ps
// Second pipeline stage: applies the term signs and adds the products in pairs.
// Depends on qalu_pkg.
module qalu_sum_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  qalu_pkg::s1_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output qalu_pkg::s2_t  out_data
);

  qalu_pkg::pair_t term [qalu_pkg::NUM_COMP][qalu_pkg::NUM_COMP];
  qalu_pkg::s2_t   data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    for (int c = 0; c < qalu_pkg::NUM_COMP; c++) begin
      for (int t = 0; t < qalu_pkg::NUM_COMP; t++) begin
        if (qalu_pkg::TERM_NEG[c][t]) begin
          term[c][t] = -qalu_pkg::pair_t'($signed(in_data.prod[c][t]));
        end else begin
          term[c][t] = qalu_pkg::pair_t'($signed(in_data.prod[c][t]));
        end
      end
    end
  end

  always_comb begin
    data_next.op     = in_data.op;
    data_next.eq     = in_data.eq;
    data_next.addsub = in_data.addsub;
    for (int c = 0; c < qalu_pkg::NUM_COMP; c++) begin
      for (int h = 0; h < 2; h++) begin
        data_next.pair[c][h] = term[c][2*h] + term[c][2*h+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

### rtl/qalu_out_stage.sv
`timescale 1ns / 1ps
// Final pipeline stage: last addition, fraction shift, saturation and the output
// register that drives the result stream. Depends on qalu_pkg.
module qalu_out_stage (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  qalu_pkg::s2_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [qalu_pkg::OUT_DATA_W-1:0]  out_data,
  output logic [qalu_pkg::OUT_USER_W-1:0]  out_user
);

  qalu_pkg::sum_t  shr   [qalu_pkg::NUM_COMP];
  qalu_pkg::comp_t mul_q [qalu_pkg::NUM_COMP];
  qalu_pkg::comp_t add_q [qalu_pkg::NUM_COMP];
  qalu_pkg::comp_t res   [qalu_pkg::NUM_COMP];
  logic [qalu_pkg::NUM_COMP-1:0]           mul_o;
  logic [qalu_pkg::NUM_COMP-1:0]           add_o;
  logic                                    eq_next;
  logic                                    ovf_next;
  logic [qalu_pkg::OUT_DATA_W-1:0]         data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    for (int c = 0; c < qalu_pkg::NUM_COMP; c++) begin
      shr[c] = (qalu_pkg::sum_t'($signed(in_data.pair[c][0]))
              + qalu_pkg::sum_t'($signed(in_data.pair[c][1]))) >>> qalu_pkg::FRAC_BITS;
      if (shr[c] > qalu_pkg::sum_t'(qalu_pkg::COMP_MAX)) begin
        mul_q[c] = qalu_pkg::COMP_MAX;
        mul_o[c] = 1'b1;
      end else if (shr[c] < qalu_pkg::sum_t'(qalu_pkg::COMP_MIN)) begin
        mul_q[c] = qalu_pkg::COMP_MIN;
        mul_o[c] = 1'b1;
      end else begin
        mul_q[c] = qalu_pkg::COMP_WIDTH'(shr[c]);
        mul_o[c] = 1'b0;
      end
      if ($signed(in_data.addsub[c]) > qalu_pkg::add_t'(qalu_pkg::COMP_MAX)) begin
        add_q[c] = qalu_pkg::COMP_MAX;
        add_o[c] = 1'b1;
      end else if ($signed(in_data.addsub[c]) < qalu_pkg::add_t'(qalu_pkg::COMP_MIN)) begin
        add_q[c] = qalu_pkg::COMP_MIN;
        add_o[c] = 1'b1;
      end else begin
        add_q[c] = qalu_pkg::COMP_WIDTH'(in_data.addsub[c]);
        add_o[c] = 1'b0;
      end
    end
  end

  always_comb begin
    unique case (in_data.op)
      qalu_pkg::OP_ADD, qalu_pkg::OP_SUB: begin
        res      = add_q;
        ovf_next = |add_o;
        eq_next  = 1'b0;
      end
      qalu_pkg::OP_MUL: begin
        res      = mul_q;
        ovf_next = |mul_o;
        eq_next  = 1'b0;
      end
      default: begin
        res      = '{default: '0};
        ovf_next = 1'b0;
        eq_next  = in_data.eq;
      end
    endcase
    for (int c = 0; c < qalu_pkg::NUM_COMP; c++) begin
      data_next[c*qalu_pkg::FIELD_W +: qalu_pkg::FIELD_W] = qalu_pkg::field_t'(res[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data                      <= data_next;
      out_user[qalu_pkg::USER_EQUAL] <= eq_next;
      out_user[qalu_pkg::USER_OVF]   <= ovf_next;
    end
  end

endmodule

### rtl/quaternion_alu_top.sv
`timescale 1ns / 1ps
// Top level of the quaternion ALU: add, subtract, Hamilton product and compare on Q16.16.
// Instantiates qalu_mul_stage, qalu_sum_stage and qalu_out_stage; depends on qalu_pkg.
//
// Operands arrive on the s_ channel, one word per operation: s_tuser carries the
// operation code and s_tdata the two quaternions. Results leave on the m_ channel,
// one word per input word, in input order.
// The pipeline has three register stages: products, paired sums, then final sum,
// shift and saturation in the output register. A word accepted into the product register
// moves through the paired-sum register to the output register, where m_tvalid shows it.
// One word is accepted every cycle while s_tready is high; sixteen 32 by 32 multipliers,
// one per product term, let every stage take a new word each cycle that it is not stalled.
// Each stage moves on whenever the stage after it is empty or moving, so bubbles are
// squeezed out and a stalled receiver fills the pipeline before s_tready drops.
// While m_tready is low the result word holds steady and nothing is lost or repeated.
// Reset clears every stage's valid bit; no word is in flight afterwards.
module quaternion_alu_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // left_r, left_i, left_j, left_k, right_r, right_i, right_j, right_k
  input  logic [qalu_pkg::IN_DATA_W-1:0]   s_tdata,
  // func
  input  logic [qalu_pkg::IN_USER_W-1:0]   s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // res_r, res_i, res_j, res_k
  output logic [qalu_pkg::OUT_DATA_W-1:0]  m_tdata,
  // equal, overflow
  output logic [qalu_pkg::OUT_USER_W-1:0]  m_tuser
);

  logic          s1_valid;
  logic          s1_ready;
  qalu_pkg::s1_t s1_data;
  logic          s2_valid;
  logic          s2_ready;
  qalu_pkg::s2_t s2_data;

  qalu_mul_stage u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (qalu_pkg::op_t'(s_tuser)),
    .in_data   (s_tdata),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  qalu_sum_stage u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  qalu_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_user  (m_tuser)
  );

endmodule

### rtl/qalu_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the quaternion ALU, bound to the top level.
// Depends on qalu_pkg and the macros in quaternion_alu_top_defines.svh.
`include "quaternion_alu_top_defines.svh"

module qalu_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [qalu_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic [qalu_pkg::OUT_USER_W-1:0]  m_tuser
);

  `QALU_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "Result word changed while stalled.")

  `QALU_ASSERT_RESET(a_reset, rst, !m_tvalid, "Result valid after reset.")

  `QALU_ASSERT_IMPL(a_cmp_flags, m_tvalid && m_tuser[qalu_pkg::USER_EQUAL], !m_tuser[qalu_pkg::USER_OVF] && (m_tdata == '0), "Compare result carries data or overflow.")

  `QALU_ASSERT_NEXT(a_latency, (s_tvalid && s_tready) ##1 m_tready ##1 m_tready, m_tvalid, "Accepted word did not reach the output in three cycles.")

endmodule

bind quaternion_alu_top qalu_checker u_qalu_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

### test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for quaternion_alu_top: add, subtract, Hamilton product and compare.
// Depends on qalu_pkg and the RTL only; expected words come from an in-bench Q16.16 calculation.
module tb;
  import qalu_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1350;
  localparam int BURST_ITEMS = 300;

  typedef logic [NUM_COMP-1:0][FIELD_W-1:0] quat_t;
  typedef struct packed {
    quat_t comp;
    logic  overflow;
    logic  equal;
  } alu_word_t;
  typedef logic signed [SUM_W+5:0] wide_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [IN_USER_W-1:0] s_tuser = OP_ADD;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;

  alu_word_t pending_results[$];
  bit src_idle_en = 1'b1;
  bit snk_idle_en = 1'b1;
  int mismatches = 0;
  int cycles = 0;
  int op_count[4] = '{0, 0, 0, 0};
  int saturated_words = 0;
  int equal_words = 0;

  quaternion_alu_top dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               pending_results.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= snk_idle_en ? ($urandom_range(99) >= 13) : 1'b1;
  end

  function automatic wide_t widen(logic [FIELD_W-1:0] f);
    logic signed [COMP_WIDTH-1:0] c;
    c = f[COMP_WIDTH-1:0];
    return wide_t'(c);
  endfunction

  function automatic wide_t clamp(wide_t v, inout logic ovf);
    wide_t lim;
    lim = wide_t'(1) <<< (COMP_WIDTH - 1);
    if (v > lim - 1) begin
      ovf = 1'b1;
      return lim - 1;
    end
    if (v < -lim) begin
      ovf = 1'b1;
      return -lim;
    end
    return v;
  endfunction

  function automatic alu_word_t quat_alu_result(op_t func, quat_t lhs, quat_t rhs);
    wide_t l[4];
    wide_t r[4];
    wide_t q[4];
    alu_word_t res;
    logic ovf;
    ovf = 1'b0;
    res = '0;
    for (int n = 0; n < 4; n++) begin
      l[n] = widen(lhs[n]);
      r[n] = widen(rhs[n]);
      q[n] = '0;
    end
    case (func)
      OP_ADD, OP_SUB: begin
        for (int n = 0; n < 4; n++) q[n] = (func == OP_ADD) ? l[n] + r[n] : l[n] - r[n];
      end
      OP_MUL: begin
        // Full-width Hamilton sums, floored by the arithmetic shift.
        q[0] = (l[0] * r[0] - l[1] * r[1] - l[2] * r[2] - l[3] * r[3]) >>> FRAC_BITS;
        q[1] = (l[0] * r[1] + l[1] * r[0] + l[2] * r[3] - l[3] * r[2]) >>> FRAC_BITS;
        q[2] = (l[0] * r[2] - l[1] * r[3] + l[2] * r[0] + l[3] * r[1]) >>> FRAC_BITS;
        q[3] = (l[0] * r[3] + l[1] * r[2] - l[2] * r[1] + l[3] * r[0]) >>> FRAC_BITS;
      end
      default: begin
        res.equal = (l[0] == r[0]) && (l[1] == r[1]) && (l[2] == r[2]) && (l[3] == r[3]);
      end
    endcase
    if (func != OP_CMP) begin
      for (int n = 0; n < 4; n++) q[n] = clamp(q[n], ovf);
    end
    for (int n = 0; n < 4; n++) res.comp[n] = q[n][FIELD_W-1:0];
    res.overflow = ovf;
    return res;
  endfunction

  always @(posedge clk) begin : watch_results
    alu_word_t got;
    alu_word_t want;
    logic bad;
    if (!rst && m_tvalid && m_tready) begin
      got.comp = m_tdata;
      got.equal = m_tuser[USER_EQUAL];
      got.overflow = m_tuser[USER_OVF];
      if (got.overflow) saturated_words++;
      if (got.equal) equal_words++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h at cycle %0d", got, cycles);
      end else begin
        want = pending_results.pop_front();
        bad = (got.equal !== want.equal) || (got.overflow !== want.overflow);
        for (int n = 0; n < NUM_COMP; n++) bad |= (got.comp[n] !== want.comp[n]);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at cycle %0d: expected r %h i %h j %h k %h eq %b ovf %b", cycles,
                     want.comp[0], want.comp[1], want.comp[2], want.comp[3], want.equal,
                     want.overflow);
            $display("                    actual   r %h i %h j %h k %h eq %b ovf %b",
                     got.comp[0], got.comp[1], got.comp[2], got.comp[3], got.equal,
                     got.overflow);
          end
        end
      end
    end
  end

  task automatic send_op(op_t func, quat_t lhs, quat_t rhs);
    while (src_idle_en && $urandom_range(99) < 13) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {rhs, lhs};
    s_tuser <= func;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(quat_alu_result(func, lhs, rhs));
    op_count[func]++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic logic [FIELD_W-1:0] rand_comp();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom();
      default: return 32'($urandom_range(32'h000F_FFFF)) - 32'h0008_0000;
    endcase
  endfunction

  function automatic quat_t rand_quat();
    quat_t q;
    for (int n = 0; n < NUM_COMP; n++) q[n] = rand_comp();
    return q;
  endfunction

  task automatic send_random();
    op_t func;
    quat_t lhs;
    quat_t rhs;
    func = op_t'(2'($urandom_range(3)));
    lhs = rand_quat();
    rhs = rand_quat();
    if (func == OP_CMP && $urandom_range(1)) begin
      rhs = lhs;
      if ($urandom_range(1)) rhs[$urandom_range(3)][$urandom_range(31)] ^= 1'b1;
    end
    send_op(func, lhs, rhs);
  endtask

  task automatic test_add_sub_edges();
    quat_t top;
    quat_t bottom;
    top = {4{32'h7FFF_FFFF}};
    bottom = {4{32'h8000_0000}};
    send_op(OP_ADD, '0, '0);
    send_op(OP_ADD, top, top);
    send_op(OP_ADD, bottom, bottom);
    send_op(OP_ADD, top, bottom);
    send_op(OP_SUB, top, bottom);
    send_op(OP_SUB, bottom, top);
    send_op(OP_SUB, '0, bottom);
    send_op(OP_SUB, {32'h1, 32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0001},
            {32'h2, 32'h1, 32'hFFFF_0000, 32'h1});
  endtask

  task automatic test_hamilton_product();
    quat_t top;
    quat_t bottom;
    top = {4{32'h7FFF_FFFF}};
    bottom = {4{32'h8000_0000}};
    send_op(OP_MUL, {32'h0, 32'h0, 32'h0, 32'h0001_0000}, {32'h0, 32'h0, 32'h0, 32'h0001_0000});
    // i times j gives k, j times i gives minus k.
    send_op(OP_MUL, {32'h0, 32'h0, 32'h0001_0000, 32'h0}, {32'h0, 32'h0001_0000, 32'h0, 32'h0});
    send_op(OP_MUL, {32'h0, 32'h0001_0000, 32'h0, 32'h0}, {32'h0, 32'h0, 32'h0001_0000, 32'h0});
    // Tiny negative products floor to minus one LSB rather than to zero.
    send_op(OP_MUL, {4{32'hFFFF_FFFF}}, {32'h0, 32'h0, 32'h0, 32'h1});
    send_op(OP_MUL, {4{32'h1}}, {4{32'h1}});
    send_op(OP_MUL, top, top);
    send_op(OP_MUL, bottom, bottom);
    send_op(OP_MUL, top, bottom);
    send_op(OP_MUL, {32'h0003_8000, 32'hFFFE_4000, 32'h0000_C000, 32'hFFFF_0001},
            {32'hFFFD_2000, 32'h0002_0000, 32'h0007_FFFF, 32'hFFFF_8000});
  endtask

  task automatic test_compare();
    quat_t q;
    q = rand_quat();
    send_op(OP_CMP, q, q);
    send_op(OP_CMP, {4{32'h8000_0000}}, {4{32'h8000_0000}});
    send_op(OP_CMP, q, {q[3] ^ 32'h8000_0000, q[2:0]});
    send_op(OP_CMP, q, {q[3:1], q[0] ^ 32'h1});
  endtask

  task automatic test_random_stream();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      send_random();
      // Halfway through, hold the sender off until the pipeline has emptied.
      if (n == RANDOM_ITEMS / 2) wait_drained();
    end
  endtask

  task automatic test_back_to_back();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    for (int n = 0; n < BURST_ITEMS; n++) send_random();
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_add_sub_edges();
    test_hamilton_product();
    test_compare();
    test_random_stream();
    test_back_to_back();
    wait_drained();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) mismatches++;
    $display("%0d words: %0d add, %0d sub, %0d mul, %0d cmp; %0d saturated, %0d equal",
             op_count[0] + op_count[1] + op_count[2] + op_count[3], op_count[0], op_count[1],
             op_count[2], op_count[3], saturated_words, equal_words);
    $display("%0d mismatches in %0d cycles", mismatches, cycles);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
